>>> rtl/apd_pkg.sv
// Shared types, constants and fixed-point helpers for the allpass cascade.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package apd_pkg;

  localparam int MAX_STAGES  = 128;
  localparam int SAMPLE_BITS = 24;
  localparam int STATE_BITS  = SAMPLE_BITS + 2;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 15;
  localparam int COUNT_BITS  = 8;
  localparam int STAGE_W     = $clog2(MAX_STAGES);
  localparam int CNT_W       = $clog2(MAX_STAGES + 1);
  localparam int RING_N      = MAX_STAGES - 1;
  localparam int PROD_W      = STATE_BITS + COEF_BITS;
  localparam int RND_W       = PROD_W - COEF_FRAC;
  localparam int SUM_W       = RND_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT = CFG_IDX_W'(1);

  localparam logic [COUNT_BITS-1:0] STAGE_COUNT_RESET = COUNT_BITS'(1);
  localparam logic [COEF_BITS-1:0]  COEFFICIENT_RESET = COEF_BITS'(16384);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [RND_W-1:0]       scaled_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // One allpass stage: two delay slots and the slot toggle.
  typedef struct packed {
    state_t slot0;
    state_t slot1;
    logic   tgl;
  } cell_t;

  // Controls from the sequencer to the arithmetic stage.
  typedef struct packed {
    logic first;   // head cell is stage zero: take the input sample
    logic act;     // head stage is within the configured count
    logic adv;     // rotate the ring by one
    logic settle;  // commit the pending write-back in place
  } pe_ctl_t;

  // a * v rounded half up to the sample scale.
  function automatic scaled_t scale(coef_t a, state_t v);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    prod    = PROD_W'(a) * PROD_W'(v);
    biased  = prod + PROD_W'(1 << (COEF_FRAC - 1));
    shifted = biased >>> COEF_FRAC;
    return shifted[RND_W-1:0];
  endfunction

  function automatic state_t sat_state(sum_t v);
    logic [SUM_W-STATE_BITS:0] top;
    top = v[SUM_W-1:STATE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[STATE_BITS-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
  endfunction

  function automatic sample_t sat_sample(state_t v);
    logic [STATE_BITS-SAMPLE_BITS:0] top;
    top = v[STATE_BITS-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end
    return v[STATE_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                           : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  // Stage count limited to one through MAX_STAGES.
  function automatic logic [CNT_W-1:0] clamp_count(logic [COUNT_BITS-1:0] sc);
    if (sc == '0) begin
      return CNT_W'(1);
    end
    if (int'(sc) > MAX_STAGES) begin
      return CNT_W'(MAX_STAGES);
    end
    return CNT_W'(sc);
  endfunction

endpackage

>>> rtl/apd_in_if.sv
// Input sample channel: valid/ready handshake with one signed sample.
// Depends on apd_pkg for the sample type.
interface apd_in_if;
  logic             valid;
  logic             ready;
  apd_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

>>> rtl/apd_out_if.sv
// Output sample channel: valid/ready handshake with one signed sample.
// Depends on apd_pkg for the sample type.
interface apd_out_if;
  logic             valid;
  logic             ready;
  apd_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/apd_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on apd_pkg for field widths.
interface apd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [apd_pkg::CFG_IDX_W-1:0]    index;
  logic [apd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/apd_cell.sv
// One position of the state ring: holds a stage's delay slots and toggle,
// takes its neighbor's contents on each rotate. Depends on apd_pkg.
module apd_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  apd_pkg::cell_t nbr,
  output apd_pkg::cell_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (adv) begin
      q <= nbr;
    end
  end

endmodule

>>> rtl/apd_pe.sv
// Arithmetic position of the ring: computes a stage's output from the head
// cell, then writes the updated slot back on the next rotate. Depends on apd_pkg.
module apd_pe (
  input  logic             clk,
  input  logic             rst,
  input  apd_pkg::pe_ctl_t ctl,
  input  apd_pkg::coef_t   coef,
  input  apd_pkg::state_t  x0,
  input  apd_pkg::cell_t   head,
  output apd_pkg::state_t  y_now,
  output apd_pkg::cell_t   wb
);

  apd_pkg::cell_t  p_cell;
  apd_pkg::state_t p_x;
  apd_pkg::state_t p_y;
  logic            p_act;

  apd_pkg::state_t x_cur;
  apd_pkg::state_t d;
  apd_pkg::state_t upd;

  assign x_cur = ctl.first ? x0 : p_y;
  assign d     = head.tgl ? head.slot1 : head.slot0;

  // y = d - a*x
  assign y_now = apd_pkg::sat_state(apd_pkg::SUM_W'(d)
                 - apd_pkg::SUM_W'(apd_pkg::scale(coef, x_cur)));

  // stored value x + a*y, from the registered x and y
  assign upd = apd_pkg::sat_state(apd_pkg::SUM_W'(p_x)
               + apd_pkg::SUM_W'(apd_pkg::scale(coef, p_y)));

  always_comb begin
    wb = p_cell;
    if (p_act) begin
      if (p_cell.tgl) begin
        wb.slot1 = upd;
      end else begin
        wb.slot0 = upd;
      end
      wb.tgl = ~p_cell.tgl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_cell <= '0;
      p_act  <= 1'b0;
    end else if (ctl.adv) begin
      p_cell <= head;
      p_act  <= ctl.act;
    end else if (ctl.settle) begin
      p_cell <= wb;
      p_act  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      p_x <= x_cur;
      p_y <= y_now;
    end
  end

endmodule

>>> rtl/allpass_cascade_dispersion.sv
// Cascaded allpass dispersion filter, top level.
// Channels: din takes one signed Q1.23 sample per item; dout gives one
// saturated Q1.23 sample per input item, in order; cfg writes register 0
// (stage count, clamped to 1..128) and register 1 (coefficient, Q1.15).
// cfg is always ready; write it only while no item is in flight.
// The stage states live in a ring of 128 positions: 127 holding cells and
// one arithmetic position. An item rotates the ring once, one stage per
// cycle except while held at its last active stage (of N, the clamped
// stage count), where its result is registered; the ring then finishes
// its turn, and a new item can be taken from the commit step on. The single
// arithmetic position, with its two multipliers, serves every stage.
// Reset clears all delay slots and toggles, sets stage count to 1 and the
// coefficient to one half, and empties the output register.
// If the receiver stalls, the finished item waits in the output register;
// the next item runs until its last active stage and holds there until
// the output register is free.
// Depends on apd_pkg, apd_in_if, apd_out_if, apd_cfg_if, apd_cell, apd_pe.
module allpass_cascade_dispersion (
  input  logic      clk,
  input  logic      rst,
  apd_in_if.sink    din,
  apd_out_if.source dout,
  apd_cfg_if.sink   cfg
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_SETTLE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [apd_pkg::STAGE_W-1:0]    cnt;
  logic [apd_pkg::COUNT_BITS-1:0] stage_count;
  apd_pkg::coef_t                 coef;
  apd_pkg::state_t                x0;
  apd_pkg::sample_t               out_sample;
  logic                           out_valid;

  logic [apd_pkg::CNT_W-1:0] n_eff;
  logic                      active;
  logic                      last;
  logic                      out_free;
  logic                      accept;
  logic                      adv;
  apd_pkg::pe_ctl_t          ctl;
  apd_pkg::state_t           y_now;
  apd_pkg::cell_t            wb;
  apd_pkg::cell_t            ring [apd_pkg::RING_N];

  assign n_eff    = apd_pkg::clamp_count(stage_count);
  assign active   = apd_pkg::CNT_W'(cnt) < n_eff;
  assign last     = apd_pkg::CNT_W'(cnt) == (n_eff - apd_pkg::CNT_W'(1));
  assign out_free = !out_valid || dout.ready;
  assign din.ready = (state == ST_IDLE) || (state == ST_SETTLE);
  assign accept   = din.valid && din.ready;
  // hold the ring at the last stage while the previous result still waits
  assign adv      = (state == ST_RUN) && (!last || out_free);

  assign ctl.first  = cnt == '0;
  assign ctl.act    = active;
  assign ctl.adv    = adv;
  assign ctl.settle = state == ST_SETTLE;

  assign cfg.ready = 1'b1;

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && cnt == apd_pkg::STAGE_W'(apd_pkg::MAX_STAGES - 1)) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_next = accept ? ST_RUN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (adv) begin
        cnt <= cnt + apd_pkg::STAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x0 <= apd_pkg::STATE_BITS'(din.sample_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= apd_pkg::STAGE_COUNT_RESET;
      coef        <= apd_pkg::COEFFICIENT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        apd_pkg::REG_STAGE_COUNT: stage_count <= cfg.data[apd_pkg::COUNT_BITS-1:0];
        apd_pkg::REG_COEFFICIENT: coef        <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && last) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last) begin
      out_sample <= apd_pkg::sat_sample(y_now);
    end
  end

  apd_pe u_pe (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .coef  (coef),
    .x0    (x0),
    .head  (ring[0]),
    .y_now (y_now),
    .wb    (wb)
  );

  for (genvar i = 0; i < apd_pkg::RING_N; i++) begin : g_ring
    apd_pkg::cell_t nbr;
    if (i == apd_pkg::RING_N - 1) begin : g_tail
      assign nbr = wb;
    end else begin : g_body
      assign nbr = ring[i+1];
    end
    apd_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .nbr (nbr),
      .q   (ring[i])
    );
  end

endmodule

>>> bench/tb_allpass_cascade_dispersion.sv
`timescale 1ns / 1ps
// Self-checking bench for allpass_cascade_dispersion: directed rows, then random phases.
// Needs apd_pkg, the three channel interfaces and the block itself from rtl/.
module tb_allpass_cascade_dispersion;

  localparam logic [apd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_2 = apd_pkg::CFG_IDX_W'(2);
  localparam logic [apd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_3 = apd_pkg::CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = apd_pkg::MAX_STAGES + 16;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [apd_pkg::CFG_IDX_W-1:0]  idx;
    logic [apd_pkg::CFG_DATA_W-1:0] data;
    apd_pkg::sample_t               sample;
    logic                           typed;
    apd_pkg::sample_t               golden;
  } dir_row_t;

  localparam int NUM_ROWS = 33;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // state all zero after reset, a = 0.5, one stage
    '{ROW_ITEM, '0, '0, 24'h000000, 1'b1, 24'h000000},
    '{ROW_ITEM, '0, '0, 24'h7FFFFF, 1'b1, 24'hC00000},
    '{ROW_ITEM, '0, '0, 24'h800000, 1'b1, 24'h400000},
    '{ROW_ITEM, '0, '0, 24'hFFFFFF, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h000001, 1'b0, '0},
    // coefficient of exactly minus one, output saturation
    '{ROW_CFG, apd_pkg::REG_COEFFICIENT, 16'h8000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h7FFFFF, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h7FFFFF, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h800000, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h800000, 1'b0, '0},
    '{ROW_CFG, apd_pkg::REG_COEFFICIENT, 16'h7FFF, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h7FFFFF, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h800000, 1'b0, '0},
    // zero count runs one stage
    '{ROW_CFG, apd_pkg::REG_STAGE_COUNT, 16'h0000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h123456, 1'b0, '0},
    // counts of the maximum and above run every stage
    '{ROW_CFG, apd_pkg::REG_STAGE_COUNT, 16'h00FF, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h7FFFFF, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h800000, 1'b0, '0},
    '{ROW_CFG, apd_pkg::REG_STAGE_COUNT, 16'h0081, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h5A5A5A, 1'b0, '0},
    '{ROW_CFG, apd_pkg::REG_STAGE_COUNT, 16'h0080, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'hA5A5A5, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h7FFFFF, 1'b0, '0},
    // writes past the register list leave everything alone
    '{ROW_CFG, REG_UNMAPPED_2, 16'h1234, '0, 1'b0, '0},
    '{ROW_CFG, REG_UNMAPPED_3, 16'hFFFF, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h000000, 1'b0, '0},
    // upper data bits of the count are dropped; further coefficient and count writes
    '{ROW_CFG, apd_pkg::REG_STAGE_COUNT, 16'h0305, '0, 1'b0, '0},
    '{ROW_CFG, apd_pkg::REG_COEFFICIENT, 16'h0000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h400000, 1'b0, '0},
    '{ROW_CFG, apd_pkg::REG_COEFFICIENT, 16'hC000, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h3FFFFF, 1'b0, '0},
    '{ROW_CFG, apd_pkg::REG_STAGE_COUNT, 16'h0002, '0, 1'b0, '0},
    '{ROW_ITEM, '0, '0, 24'h800001, 1'b0, '0}
  };

  logic clk;
  logic rst;

  apd_in_if  din_ch();
  apd_out_if dout_ch();
  apd_cfg_if cfg_ch();

  allpass_cascade_dispersion uut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch),
    .cfg  (cfg_ch)
  );

  // Mirror of the filter state and registers
  apd_pkg::state_t                ap_slot [2*apd_pkg::MAX_STAGES];
  bit                             ap_toggle [apd_pkg::MAX_STAGES];
  logic [apd_pkg::COUNT_BITS-1:0] ap_count;
  apd_pkg::coef_t                 ap_coef;

  apd_pkg::sample_t pending_outputs [$];
  int               errors;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // a * v, rounded half up back to the sample scale
  function automatic longint coef_round(longint v);
    longint prod;
    prod = longint'(ap_coef) * v;
    return (prod + (longint'(1) << (apd_pkg::COEF_FRAC - 1))) >>> apd_pkg::COEF_FRAC;
  endfunction

  function automatic apd_pkg::sample_t disperse(apd_pkg::sample_t s);
    int     n;
    int     slot;
    longint x;
    longint d;
    longint y;
    n = int'(ap_count);
    if (n == 0) n = 1;
    else if (n > apd_pkg::MAX_STAGES) n = apd_pkg::MAX_STAGES;
    x = s;
    for (int k = 0; k < n; k++) begin
      slot = 2 * k + int'(ap_toggle[k]);
      d = ap_slot[slot];
      y = clip(d - coef_round(x), apd_pkg::STATE_BITS);
      ap_slot[slot] = apd_pkg::state_t'(clip(x + coef_round(y), apd_pkg::STATE_BITS));
      ap_toggle[k] = ~ap_toggle[k];
      x = y;
    end
    return apd_pkg::sample_t'(clip(x, apd_pkg::SAMPLE_BITS));
  endfunction

  task automatic note_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_sample(apd_pkg::sample_t s, logic typed, apd_pkg::sample_t golden);
    int               gap;
    apd_pkg::sample_t predicted;
    gap = 0;
    if (send_idle_pct > 0) begin
      if ($urandom_range(7) == 0) gap = $urandom_range(1, 2 * apd_pkg::MAX_STAGES);
      else while ($urandom_range(99) < send_idle_pct) gap++;
    end
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid     <= 1'b1;
    din_ch.sample_in <= s;
    do @(posedge clk); while (!din_ch.ready);
    predicted = disperse(s);
    pending_outputs.push_back(typed ? golden : predicted);
  endtask

  // Hold the input off until every result is out and the ring has settled
  task automatic drain();
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [apd_pkg::CFG_IDX_W-1:0] idx,
                           logic [apd_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == apd_pkg::REG_STAGE_COUNT) ap_count = data[apd_pkg::COUNT_BITS-1:0];
    else if (idx == apd_pkg::REG_COEFFICIENT) ap_coef = apd_pkg::coef_t'(data);
    @(posedge clk);
  endtask

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_BOTH) ? 33 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 33 : 0;
  endtask

  function automatic apd_pkg::sample_t random_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return apd_pkg::sample_t'(int'($urandom_range(255)) - 128);
      3: return '0;
      default: return apd_pkg::sample_t'($urandom());
    endcase
  endfunction

  // Receiver: random stalls, with an occasional long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      dout_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (recv_stall_pct > 0 && $urandom_range(63) == 0) begin
      dout_ch.ready <= 1'b0;
      stall_left <= $urandom_range(1, 3 * apd_pkg::MAX_STAGES);
    end else begin
      dout_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    apd_pkg::sample_t want;
    if (!rst && dout_ch.valid && dout_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        note_error($sformatf("unexpected sample_out %0d", dout_ch.sample_out));
      end else begin
        want = pending_outputs.pop_front();
        if (dout_ch.sample_out !== want) begin
          note_error($sformatf("sample_out %0d, expected %0d", dout_ch.sample_out, want));
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int         phase_counts [PHASES];
    int         phase_coefs [PHASES];
    logic [7:0] count_val;
    phase_counts = '{1, 128, -1, 3, 0, 200, -2, 64};
    phase_coefs  = '{-32768, 32767, 0, -1, 16384, 1, 99999, 99999};
    clk = 1'b0;
    rst = 1'b1;
    din_ch.valid = 1'b0;
    din_ch.sample_in = '0;
    dout_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    errors = 0;
    stall_left = 0;
    set_idling(IDLE_NONE);
    for (int i = 0; i < 2 * apd_pkg::MAX_STAGES; i++) ap_slot[i] = '0;
    for (int i = 0; i < apd_pkg::MAX_STAGES; i++) ap_toggle[i] = 1'b0;
    ap_count = apd_pkg::STAGE_COUNT_RESET;
    ap_coef  = apd_pkg::coef_t'(apd_pkg::COEFFICIENT_RESET);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
        drain();
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
      end else begin
        send_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].golden);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // negative entries pick a random count: -1 any, -2 a short cascade
      if (phase_counts[p] == -1) count_val = 8'($urandom_range(255));
      else if (phase_counts[p] == -2) count_val = 8'($urandom_range(1, 16));
      else count_val = 8'(phase_counts[p]);
      write_reg(apd_pkg::REG_STAGE_COUNT, {8'($urandom()), count_val});
      write_reg(apd_pkg::REG_COEFFICIENT,
                (phase_coefs[p] == 99999) ? apd_pkg::CFG_DATA_W'($urandom())
                                          : apd_pkg::CFG_DATA_W'(phase_coefs[p]));
      set_idling(idle_mode_t'(p % 4));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == ITEMS_PER_PHASE / 2) drain();
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/apd_pkg.sv
rtl/apd_in_if.sv
rtl/apd_out_if.sv
rtl/apd_cfg_if.sv
rtl/apd_cell.sv
rtl/apd_pe.sv
rtl/allpass_cascade_dispersion.sv
bench/tb_allpass_cascade_dispersion.sv
